### rtl/dcma_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// dcma_pkg
// Shared types and constants of the dual channel moving average unit.
// ----------------------------------------------------------------------------
package dcma_pkg;

  localparam int unsigned CHAN_W      = 5;
  localparam int unsigned IN_SAMPLE_W = 12;
  localparam int unsigned AVG_W       = 12;

  localparam int unsigned WINDOW_DEF      = 8;
  localparam int unsigned SAMPLE_BITS_DEF = 12;
  localparam int unsigned QUEUE_DEPTH     = 2;

  // Configuration port
  localparam int unsigned CFG_IDX_W  = 1;
  localparam int unsigned CFG_DATA_W = 5;

  localparam logic [CFG_IDX_W-1:0] CFG_FIRST  = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_SECOND = 1'b1;

  localparam logic [CHAN_W-1:0] FIRST_RESET  = 5'd0;
  localparam logic [CHAN_W-1:0] SECOND_RESET = 5'd16;

  typedef struct packed {
    logic [CHAN_W-1:0]      channel;
    logic [IN_SAMPLE_W-1:0] sample;
  } in_t;

  typedef struct packed {
    logic             slot;
    logic [AVG_W-1:0] average;
  } out_t;

  typedef struct packed {
    logic [CHAN_W-1:0] first_channel;
    logic [CHAN_W-1:0] second_channel;
  } cfg_t;

endpackage : dcma_pkg
`default_nettype wire

### rtl/dual_channel_moving_average_unit.sv
`default_nettype none
// ----------------------------------------------------------------------------
// dual_channel_moving_average_unit
// Eight sample moving average over two configurable converter channels.
// ----------------------------------------------------------------------------
// Channel  Direction  Handshake            Payload
// in       input      in_valid_i/in_stall_o   in_i  (channel, sample)
// out      output     out_valid_o/out_stall_i out_o (slot, average)
// cfg      input      cfg_we_i                cfg_idx_i, cfg_data_i
//
// The back end works on one matched sample at a time: it reads the store, runs
// the one bit per cycle restoring divider, then loads the output register.
// Unmatched samples are dropped in the front end.
// A two entry queue lets the front end keep accepting while the back end works.
// Reset clears the sums, positions and fill counts; store entries past the
// fill count read as zero, so no clearing pass is needed.
// ----------------------------------------------------------------------------
module dual_channel_moving_average_unit #(
  parameter int unsigned WINDOW      = dcma_pkg::WINDOW_DEF,
  parameter int unsigned SAMPLE_BITS = dcma_pkg::SAMPLE_BITS_DEF
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          cfg_we_i,
  input  wire logic [dcma_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  wire logic [dcma_pkg::CFG_DATA_W-1:0] cfg_data_i,
  input  wire logic                          in_valid_i,
  input  wire dcma_pkg::in_t                 in_i,
  output logic                               in_stall_o,
  output logic                               out_valid_o,
  input  wire logic                          out_stall_i,
  output dcma_pkg::out_t                     out_o
);
  import dcma_pkg::*;

  localparam int unsigned JOB_W = SAMPLE_BITS + 1;

  cfg_t             cfg_q;
  logic             q_push, q_full, q_pop, q_empty;
  logic [JOB_W-1:0] q_wdata, q_rdata;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.first_channel  <= FIRST_RESET;
      cfg_q.second_channel <= SECOND_RESET;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_FIRST:  cfg_q.first_channel  <= CHAN_W'(cfg_data_i);
        CFG_SECOND: cfg_q.second_channel <= CHAN_W'(cfg_data_i);
        default: ;
      endcase
    end
  end

  dcma_front #(
    .SAMPLE_BITS(SAMPLE_BITS)
  ) u_front (
    .cfg_i      (cfg_q),
    .in_valid_i (in_valid_i),
    .in_i       (in_i),
    .in_stall_o (in_stall_o),
    .push_o     (q_push),
    .job_o      (q_wdata),
    .full_i     (q_full)
  );

  dcma_fifo #(
    .WIDTH(JOB_W),
    .DEPTH(QUEUE_DEPTH)
  ) u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (q_push),
    .data_i  (q_wdata),
    .full_o  (q_full),
    .pop_i   (q_pop),
    .data_o  (q_rdata),
    .empty_o (q_empty)
  );

  dcma_back #(
    .WINDOW      (WINDOW),
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .empty_i     (q_empty),
    .job_i       (q_rdata),
    .pop_o       (q_pop),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_o       (out_o)
  );

`ifndef SYNTHESIS
  a_no_push_when_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_full |-> !q_push)
    else $error("job pushed into full queue");

  a_no_pop_when_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_empty |-> !q_pop)
    else $error("job popped from empty queue");

  a_miss_dropped: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o && in_i.channel != cfg_q.first_channel &&
     in_i.channel != cfg_q.second_channel) |-> !q_push)
    else $error("unmatched channel queued");
`endif

endmodule : dual_channel_moving_average_unit
`default_nettype wire

### rtl/dcma_fifo.sv
`default_nettype none
// ----------------------------------------------------------------------------
// dcma_fifo
// Short queue between the classifying front end and the filter back end.
// ----------------------------------------------------------------------------
module dcma_fifo #(
  parameter int unsigned WIDTH = 13,
  parameter int unsigned DEPTH = dcma_pkg::QUEUE_DEPTH
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             push_i,
  input  wire logic [WIDTH-1:0] data_i,
  output logic                  full_o,
  input  wire logic             pop_i,
  output logic [WIDTH-1:0]      data_o,
  output logic                  empty_o
);
  import dcma_pkg::*;

  localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [PTR_W-1:0] wr_ptr_q, wr_ptr_d;
  logic [PTR_W-1:0] rd_ptr_q, rd_ptr_d;
  logic [CNT_W-1:0] count_q, count_d;
  logic             do_push, do_pop;

  assign full_o  = (count_q == CNT_W'(DEPTH));
  assign empty_o = (count_q == '0);
  assign data_o  = mem_q[rd_ptr_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (do_push && !do_pop) begin
      count_d = count_q + 1'b1;
    end else if (do_pop && !do_push) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= data_i;
    end
  end

endmodule : dcma_fifo
`default_nettype wire

### rtl/dcma_front.sv
`default_nettype none
// ----------------------------------------------------------------------------
// dcma_front
// Accepts tagged samples, matches the channel against the two configured
// channels and queues a filter job for a hit. Misses are dropped.
// ----------------------------------------------------------------------------
module dcma_front #(
  parameter int unsigned SAMPLE_BITS = dcma_pkg::SAMPLE_BITS_DEF
) (
  input  wire dcma_pkg::cfg_t       cfg_i,
  input  wire logic                 in_valid_i,
  input  wire dcma_pkg::in_t        in_i,
  output logic                      in_stall_o,
  output logic                      push_o,
  output logic [SAMPLE_BITS:0]      job_o,
  input  wire logic                 full_i
);
  import dcma_pkg::*;

  // Keep only the low SAMPLE_BITS of the reading
  localparam logic [IN_SAMPLE_W-1:0] SampleMask = (SAMPLE_BITS >= IN_SAMPLE_W) ? '1 :
      IN_SAMPLE_W'((1 << SAMPLE_BITS) - 1);

  logic hit_first, hit_second;
  logic [SAMPLE_BITS-1:0] value;

  assign hit_first  = (in_i.channel == cfg_i.first_channel);
  assign hit_second = (in_i.channel == cfg_i.second_channel);
  assign value      = SAMPLE_BITS'(in_i.sample & SampleMask);

  assign in_stall_o = full_i;
  assign push_o     = in_valid_i && !full_i && (hit_first || hit_second);
  // First channel wins when both registers hold the same number
  assign job_o      = {!hit_first, value};

endmodule : dcma_front
`default_nettype wire

### rtl/dcma_back.sv
`default_nettype none
// ----------------------------------------------------------------------------
// dcma_back
// Per slot ring store, running sum and fill count, followed by a restoring
// divider that takes one quotient bit per cycle. Holds the result in an
// output register.
// ----------------------------------------------------------------------------
module dcma_back #(
  parameter int unsigned WINDOW      = dcma_pkg::WINDOW_DEF,
  parameter int unsigned SAMPLE_BITS = dcma_pkg::SAMPLE_BITS_DEF
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               empty_i,
  input  wire logic [SAMPLE_BITS:0] job_i,
  output logic                    pop_o,
  output logic                    out_valid_o,
  input  wire logic               out_stall_i,
  output dcma_pkg::out_t          out_o
);
  import dcma_pkg::*;

  localparam int unsigned POS_W  = $clog2(WINDOW);
  localparam int unsigned ADDR_W = POS_W + 1;
  localparam int unsigned CNT_W  = $clog2(WINDOW + 1);
  localparam int unsigned SUM_W  = SAMPLE_BITS + $clog2(WINDOW);
  localparam int unsigned STEP_W = $clog2(SUM_W + 1);

  localparam logic [1:0] StIdle = 2'd0;
  localparam logic [1:0] StRead = 2'd1;
  localparam logic [1:0] StDiv  = 2'd2;
  localparam logic [1:0] StDone = 2'd3;

  logic [1:0] st_q, st_d;

  logic [SAMPLE_BITS-1:0] mem_q [2**ADDR_W];
  logic [SAMPLE_BITS-1:0] rdata_q;
  logic [ADDR_W-1:0]      addr_q;
  logic                   slot_q;
  logic [SAMPLE_BITS-1:0] val_q;

  logic [SUM_W-1:0] sum_q [2];
  logic [POS_W-1:0] pos_q [2];
  logic [CNT_W-1:0] fill_q [2];

  logic [SUM_W-1:0]  quo_q, quo_d;
  logic [CNT_W-1:0]  rem_q, rem_d;
  logic [CNT_W-1:0]  dvs_q, dvs_d;
  logic [STEP_W-1:0] step_q, step_d;

  logic                   out_valid_q, out_valid_d;
  out_t                   out_q, out_d;

  logic                   head_slot;
  logic                   full_window;
  logic [SAMPLE_BITS-1:0] old_val;
  logic [SUM_W-1:0]       new_sum;
  logic [POS_W-1:0]       new_pos;
  logic [CNT_W-1:0]       new_fill;
  logic [CNT_W:0]         trial;
  logic                   ge;
  logic                   update;

  assign head_slot   = job_i[SAMPLE_BITS];
  assign pop_o       = (st_q == StIdle) && !empty_i;
  assign update      = (st_q == StRead);

  // An entry at or past the fill count was never written and reads as zero
  assign full_window = (fill_q[slot_q] == CNT_W'(WINDOW));
  assign old_val     = full_window ? rdata_q : '0;
  assign new_sum     = sum_q[slot_q] - SUM_W'(old_val) + SUM_W'(val_q);
  assign new_pos     = (pos_q[slot_q] == POS_W'(WINDOW - 1)) ? '0 : pos_q[slot_q] + 1'b1;
  assign new_fill    = full_window ? fill_q[slot_q] : fill_q[slot_q] + 1'b1;

  assign trial = {rem_q, quo_q[SUM_W-1]};
  assign ge    = (trial >= {1'b0, dvs_q});

  always_comb begin
    st_d        = st_q;
    quo_d       = quo_q;
    rem_d       = rem_q;
    dvs_d       = dvs_q;
    step_d      = step_q;
    out_valid_d = out_valid_q;
    out_d       = out_q;
    if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end
    unique case (st_q)
      StIdle: begin
        if (!empty_i) begin
          st_d = StRead;
        end
      end
      StRead: begin
        quo_d  = new_sum;
        rem_d  = '0;
        dvs_d  = new_fill;
        step_d = STEP_W'(SUM_W);
        st_d   = StDiv;
      end
      StDiv: begin
        rem_d  = ge ? CNT_W'(trial - {1'b0, dvs_q}) : CNT_W'(trial);
        quo_d  = {quo_q[SUM_W-2:0], ge};
        step_d = step_q - 1'b1;
        if (step_q == STEP_W'(1)) begin
          st_d = StDone;
        end
      end
      StDone: begin
        // Hold until the output register is free
        if (!out_valid_q || !out_stall_i) begin
          out_valid_d   = 1'b1;
          out_d.slot    = slot_q;
          out_d.average = AVG_W'(quo_q);
          st_d          = StIdle;
        end
      end
      default: st_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q        <= StIdle;
      out_valid_q <= 1'b0;
      step_q      <= '0;
      for (int i = 0; i < 2; i++) begin
        sum_q[i]  <= '0;
        pos_q[i]  <= '0;
        fill_q[i] <= '0;
      end
    end else begin
      st_q        <= st_d;
      out_valid_q <= out_valid_d;
      step_q      <= step_d;
      if (update) begin
        sum_q[slot_q]  <= new_sum;
        pos_q[slot_q]  <= new_pos;
        fill_q[slot_q] <= new_fill;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    quo_q <= quo_d;
    rem_q <= rem_d;
    dvs_q <= dvs_d;
    out_q <= out_d;
    if (pop_o) begin
      slot_q  <= head_slot;
      val_q   <= job_i[SAMPLE_BITS-1:0];
      addr_q  <= {head_slot, pos_q[head_slot]};
      rdata_q <= mem_q[{head_slot, pos_q[head_slot]}];
    end
    if (update) begin
      mem_q[addr_q] <= val_q;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_o       = out_q;

endmodule : dcma_back
`default_nettype wire

### dv/tb_top.sv
`default_nettype none
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the dual channel moving average unit. Directed
// transactions cover the reset channel map, full-scale samples, window
// saturation and wrap, unmatched channels and a shared channel number. Random
// traffic then runs through several channel maps and idle/stall patterns. A
// local model of both filter slots predicts each average, and every output
// transaction is checked against the oldest prediction.
// ----------------------------------------------------------------------------
module tb_top;
  import dcma_pkg::*;

  localparam int unsigned WINDOW_LEN   = WINDOW_DEF;
  localparam int unsigned SUM_W        = 15;
  localparam int unsigned SETTLE_CYCLES = 64;
  localparam int unsigned PHASE_ITEMS  = 440;
  localparam longint unsigned CYCLE_LIMIT = 1000000;

  logic                  clk_i = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_idx = CFG_FIRST;
  logic [CFG_DATA_W-1:0] cfg_data = '0;
  logic                  in_valid = 1'b0;
  in_t                   in_data = '0;
  logic                  in_stall;
  logic                  out_valid;
  logic                  out_stall = 1'b0;
  out_t                  out_data;

  int unsigned     src_idle_pct = 0;
  int unsigned     snk_stall_pct = 0;
  int unsigned     error_count = 0;
  longint unsigned cycle_count = 0;

  // Filter model: one ring, sum, write pointer and fill count per slot
  logic [CHAN_W-1:0]      map_first = FIRST_RESET;
  logic [CHAN_W-1:0]      map_second = SECOND_RESET;
  logic [IN_SAMPLE_W-1:0] ring [2][WINDOW_LEN];
  logic [SUM_W-1:0]       slot_sum [2];
  logic [2:0]             wr_ptr [2];
  logic [3:0]             fill [2];
  out_t                   expected_averages [$];

  dual_channel_moving_average_unit dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_n),
    .cfg_we_i   (cfg_we),
    .cfg_idx_i  (cfg_idx),
    .cfg_data_i (cfg_data),
    .in_valid_i (in_valid),
    .in_i       (in_data),
    .in_stall_o (in_stall),
    .out_valid_o(out_valid),
    .out_stall_i(out_stall),
    .out_o      (out_data)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  function automatic bit predict_average(input in_t item, output out_t result);
    int unsigned s;
    logic [SUM_W-1:0] quotient;
    result = '0;
    if (item.channel == map_first) begin
      s = 0;
    end else if (item.channel == map_second) begin
      s = 1;
    end else begin
      return 1'b0;
    end
    // replace the oldest entry and keep the running sum in step
    slot_sum[s] = slot_sum[s] - SUM_W'(ring[s][wr_ptr[s]]) + SUM_W'(item.sample);
    ring[s][wr_ptr[s]] = item.sample;
    wr_ptr[s] = (wr_ptr[s] == 3'(WINDOW_LEN - 1)) ? 3'd0 : wr_ptr[s] + 3'd1;
    if (fill[s] < 4'(WINDOW_LEN)) fill[s] = fill[s] + 4'd1;
    quotient = slot_sum[s] / SUM_W'(fill[s]);
    result.slot = s[0];
    result.average = quotient[AVG_W-1:0];
    return 1'b1;
  endfunction

  // Output side: check accepted transactions, then pick the next stall
  always @(posedge clk_i) begin
    out_t exp_res;
    if (rst_n && out_valid && !out_stall) begin
      if (expected_averages.size() == 0) begin
        $display("%0t: unexpected result slot=%0d average=%0d",
                 $time, out_data.slot, out_data.average);
        error_count++;
      end else begin
        exp_res = expected_averages.pop_front();
        if (out_data.slot !== exp_res.slot) begin
          $display("%0t: slot mismatch expected=%0d actual=%0d",
                   $time, exp_res.slot, out_data.slot);
          error_count++;
        end
        if (out_data.average !== exp_res.average) begin
          $display("%0t: average mismatch expected=%0d actual=%0d",
                   $time, exp_res.average, out_data.average);
          error_count++;
        end
      end
    end
    out_stall <= ($urandom_range(99) < snk_stall_pct);
  end

  // Returns at the accepting edge with valid still high, so the caller must
  // drive the next transaction or drop valid in the same step.
  task automatic send_sample(input logic [CHAN_W-1:0] channel,
                             input logic [IN_SAMPLE_W-1:0] sample,
                             output bit matched);
    in_t item;
    out_t res;
    int unsigned gap;
    item.channel = channel;
    item.sample = sample;
    gap = 0;
    while (gap < 20 && $urandom_range(99) < src_idle_pct) gap++;
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid <= 1'b1;
    in_data <= item;
    do @(posedge clk_i); while (in_stall);
    matched = predict_average(item, res);
    if (matched) expected_averages.push_back(res);
  endtask

  task automatic send_fixed(input logic [CHAN_W-1:0] channel,
                            input logic [IN_SAMPLE_W-1:0] sample);
    bit matched;
    send_sample(channel, sample, matched);
  endtask

  // Drop valid, let every expected result arrive, then let dropped
  // transactions clear the front end.
  task automatic drain_outputs();
    in_valid <= 1'b0;
    while (expected_averages.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_channel_map(input logic [CHAN_W-1:0] first_ch,
                                   input logic [CHAN_W-1:0] second_ch);
    cfg_we <= 1'b1;
    cfg_idx <= CFG_FIRST;
    cfg_data <= CFG_DATA_W'(first_ch);
    @(posedge clk_i);
    map_first = first_ch;
    cfg_idx <= CFG_SECOND;
    cfg_data <= CFG_DATA_W'(second_ch);
    @(posedge clk_i);
    map_second = second_ch;
    cfg_we <= 1'b0;
  endtask

  task automatic test_default_channels();
    // fill slot zero past the window at full scale, then pull it down
    repeat (9) send_fixed(FIRST_RESET, 12'hFFF);
    send_fixed(SECOND_RESET, 12'h000);
    send_fixed(SECOND_RESET, 12'hFFF);
    send_fixed(5'd31, 12'hAAA);
    send_fixed(5'd1, 12'h555);
    send_fixed(FIRST_RESET, 12'h000);
    send_fixed(FIRST_RESET, 12'h000);
    drain_outputs();
  endtask

  task automatic test_shared_channel();
    // same number in both registers: slot zero takes every match
    write_channel_map(5'd7, 5'd7);
    send_fixed(5'd7, 12'd1234);
    send_fixed(5'd7, 12'd4095);
    send_fixed(FIRST_RESET, 12'd1);
    drain_outputs();
  endtask

  task automatic test_extreme_channels();
    write_channel_map(5'd31, 5'd0);
    send_fixed(5'd31, 12'hFFF);
    send_fixed(5'd0, 12'h000);
    send_fixed(5'd16, 12'h800);
    drain_outputs();
  endtask

  task automatic test_random_traffic(input int unsigned src_pct,
                                     input int unsigned snk_pct,
                                     input logic [CHAN_W-1:0] first_ch,
                                     input logic [CHAN_W-1:0] second_ch);
    int unsigned item_count;
    int unsigned pick;
    logic [CHAN_W-1:0] channel;
    logic [IN_SAMPLE_W-1:0] sample;
    bit matched;
    write_channel_map(first_ch, second_ch);
    src_idle_pct = src_pct;
    snk_stall_pct = snk_pct;
    item_count = 0;
    while (item_count < PHASE_ITEMS) begin
      pick = $urandom_range(99);
      if (pick < 45) channel = first_ch;
      else if (pick < 85) channel = second_ch;
      else channel = CHAN_W'($urandom_range(31));
      case ($urandom_range(9))
        0: sample = '0;
        1: sample = '1;
        default: sample = IN_SAMPLE_W'($urandom_range(4095));
      endcase
      send_sample(channel, sample, matched);
      item_count++;
    end
    drain_outputs();
    src_idle_pct = 0;
    snk_stall_pct = 0;
  endtask

  initial begin
    for (int s = 0; s < 2; s++) begin
      slot_sum[s] = '0;
      wr_ptr[s] = '0;
      fill[s] = '0;
      for (int k = 0; k < WINDOW_LEN; k++) ring[s][k] = '0;
    end
    repeat (8) @(posedge clk_i);
    rst_n <= 1'b1;
    @(posedge clk_i);

    test_default_channels();
    test_shared_channel();
    test_extreme_channels();
    test_random_traffic(0, 0, CHAN_W'($urandom_range(31)), CHAN_W'($urandom_range(31)));
    test_random_traffic(56, 0, CHAN_W'($urandom_range(31)), CHAN_W'($urandom_range(31)));
    test_random_traffic(0, 56, 5'd0, 5'd31);
    test_random_traffic(25, 25, CHAN_W'($urandom_range(31)), CHAN_W'($urandom_range(31)));

    if (error_count == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule : tb_top
`default_nettype wire
